FILE: hw/rtl/mct_pkg.sv
package mct_pkg;

	// Base codes as they arrive on the input channel
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_U = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_C = 2'd3;

	// ASCII letters with a meaning of their own
	localparam logic [6:0] CHAR_MET  = 7'h4D;
	localparam logic [6:0] CHAR_STOP = 7'h2A;

	// Standard genetic code, one ASCII byte per codon,
	// codon index = first*16 + second*4 + third, entry 0 in the top byte
	localparam logic [511:0] ACID_ROM = {
		"KNKNIIMIRSRSTTTT",
		"*Y*YLFLF*CWCSSSS",
		"EDEDVVVVGGGGAAAA",
		"QHQHLLLLRRRRPPPP"
	};

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SEARCH = 2'd1,
		PH_TRANS  = 2'd2,
		PH_STOP   = 2'd3
	} phase_t;

	// Per-strand state carried from one base to the next
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  held_bases;
		logic [1:0]  bases_held_count;
		logic        strand_override;
	} strand_t;

	// One result item
	typedef struct packed {
		logic        acid_valid;
		logic [6:0]  amino_letter;
		logic        strand_done;
		logic        no_start_found;
		logic        incomplete_codon;
	} result_t;

	// Look up the amino acid letter of a codon
	function automatic logic [6:0] acid_lookup(input logic [5:0] codon);
		logic [7:0] ch;
		ch = ACID_ROM[{~codon, 3'b000} +: 8];
		return ch[6:0];
	endfunction

endpackage

FILE: hw/rtl/mct_step.sv
module mct_step (
	input  mct_pkg::strand_t  cur,
	input  logic [1:0]        base,
	input  logic              strand_end,
	input  logic              override_mode,
	output mct_pkg::strand_t  nxt,
	output mct_pkg::result_t  res,
	output logic              has_result
);

	mct_pkg::phase_t ph;
	logic [3:0]      held;
	logic [1:0]      cnt;
	logic            ovr;
	logic            acid_valid;
	logic [6:0]      letter;

	// Next strand state and result for one base
	always_comb begin
		ph         = cur.phase;
		held       = cur.held_bases;
		cnt        = cur.bases_held_count;
		ovr        = cur.strand_override;
		acid_valid = 1'b0;
		letter     = '0;

		// First base of a strand: latch the mode and open the strand
		if (ph == mct_pkg::PH_IDLE) begin
			ovr  = override_mode;
			ph   = override_mode ? mct_pkg::PH_TRANS : mct_pkg::PH_SEARCH;
			held = '0;
			cnt  = '0;
		end

		unique case (ph)
			mct_pkg::PH_SEARCH: begin
				// A then U held, G arriving: start codon
				if (cnt == 2'd2 && held == {mct_pkg::BASE_A, mct_pkg::BASE_U}
						&& base == mct_pkg::BASE_G) begin
					acid_valid = 1'b1;
					letter     = mct_pkg::CHAR_MET;
					ph         = mct_pkg::PH_TRANS;
					held       = '0;
					cnt        = '0;
				end else begin
					held = {held[1:0], base};
					if (cnt != 2'd2) begin
						cnt = cnt + 2'd1;
					end
				end
			end
			mct_pkg::PH_TRANS: begin
				if (cnt[1]) begin
					acid_valid = 1'b1;
					letter     = mct_pkg::acid_lookup({held, base});
					held       = '0;
					cnt        = '0;
					if (letter == mct_pkg::CHAR_STOP && !ovr) begin
						ph = mct_pkg::PH_STOP;
					end
				end else begin
					held = {held[1:0], base};
					cnt  = cnt + 2'd1;
				end
			end
			default: begin
				// stopped: drop the base
			end
		endcase

		res.acid_valid       = acid_valid;
		res.amino_letter     = letter;
		res.strand_done      = strand_end;
		res.no_start_found   = strand_end && (ph == mct_pkg::PH_SEARCH);
		res.incomplete_codon = strand_end && (ph == mct_pkg::PH_TRANS) && (cnt != 2'd0);
		has_result           = acid_valid || strand_end;

		// Strand end returns to idle
		if (strand_end) begin
			nxt.phase            = mct_pkg::PH_IDLE;
			nxt.held_bases       = '0;
			nxt.bases_held_count = '0;
			nxt.strand_override  = 1'b0;
		end else begin
			nxt.phase            = ph;
			nxt.held_bases       = held;
			nxt.bases_held_count = cnt;
			nxt.strand_override  = ovr;
		end
	end

endmodule

FILE: hw/rtl/mrna_codon_translator_core.sv
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_stall  | base, strand_end
// result   | out       | out_valid / out_stall| acid_valid, amino_letter, strand_done,
//          |           |                      | no_start_found, incomplete_codon
// config   | in        | cfg_wr_en            | cfg_wr_data (override_mode)
//
// One base per cycle sustained while no held result stalls the input.
// A base sits in the input register, then the codon step logic updates the
// strand state and loads the result register in the same cycle.
// Reset clears the strand state, the mode register and both valid flags.
// A held result stalls only bases that produce a result; others pass on.
module mrna_codon_translator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] base,
	input  logic       strand_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       acid_valid,
	output logic [6:0] amino_letter,
	output logic       strand_done,
	output logic       no_start_found,
	output logic       incomplete_codon
);

	logic              override_q;
	logic              valid_s1;
	logic [1:0]        base_s1;
	logic              end_s1;
	mct_pkg::strand_t  strand_q;
	mct_pkg::strand_t  strand_nxt;
	mct_pkg::result_t  res_nxt;
	mct_pkg::result_t  res_q;
	logic              has_result;
	logic              out_valid_q;
	logic              advance;
	logic              accept;

	// Write the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			override_q <= 1'b0;
		end else if (cfg_wr_en) begin
			override_q <= cfg_wr_data;
		end
	end

	// Advance the staged base when the result slot is free or not needed
	assign advance  = valid_s1 && (!has_result || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1 <= base;
			end_s1  <= strand_end;
		end
	end

	mct_step u_step (
		.cur           (strand_q),
		.base          (base_s1),
		.strand_end    (end_s1),
		.override_mode (override_q),
		.nxt           (strand_nxt),
		.res           (res_nxt),
		.has_result    (has_result)
	);

	// Strand state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strand_q <= '{phase: mct_pkg::PH_IDLE, held_bases: '0,
				bases_held_count: '0, strand_override: 1'b0};
		end else if (advance) begin
			strand_q <= strand_nxt;
		end
	end

	// Result register: load a new item, drop a taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign acid_valid       = res_q.acid_valid;
	assign amino_letter     = res_q.amino_letter;
	assign strand_done      = res_q.strand_done;
	assign no_start_found   = res_q.no_start_found;
	assign incomplete_codon = res_q.incomplete_codon;

endmodule

FILE: hw/rtl/mct_checker.sv
module mct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       acid_valid,
	input logic [6:0] amino_letter,
	input logic       strand_done,
	input logic       no_start_found,
	input logic       incomplete_codon
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(amino_letter)
			&& $stable(acid_valid) && $stable(strand_done))
		else $error("stalled result item changed");

	// Every result item carries a letter or ends a strand
	a_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> acid_valid || strand_done)
		else $error("result item with neither letter nor strand end");

	// No letter without a translated codon
	a_letter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !acid_valid |-> amino_letter == 7'd0)
		else $error("letter set without a codon");

	// End flags only at strand end, and never both
	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (no_start_found || incomplete_codon)
			|-> strand_done && !(no_start_found && incomplete_codon))
		else $error("bad end-of-strand flags");

endmodule

bind mrna_codon_translator_core mct_checker u_mct_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.acid_valid       (acid_valid),
	.amino_letter     (amino_letter),
	.strand_done      (strand_done),
	.no_start_found   (no_start_found),
	.incomplete_codon (incomplete_codon)
);
